// ===== rtl/core/gnss_cfg_pkg.sv =====
// ----------------------------------------------------------------------------
// Receiver bring-up sequencer package
// Shared constants, mode, command and register codes, and the baud candidate walk table.
// ----------------------------------------------------------------------------
package gnss_cfg_pkg;

	localparam logic [3:0] SENTENCE_COUNT     = 4'd4;
	localparam logic [3:0] RATE_CANDIDATES    = 4'd4;
	localparam logic [2:0] TARGET_RATE_INDEX  = 3'd3;
	localparam logic [2:0] DEFAULT_RATE_INDEX = 3'd0;
	localparam logic [1:0] FACTORY_KIND       = 2'd3;

	typedef enum logic [3:0] {
		MODE_IDLE        = 4'd0,
		MODE_RESTARTING  = 4'd1,
		MODE_WAKING      = 4'd2,
		MODE_IDENTIFYING = 4'd3,
		MODE_SENDING     = 4'd4,
		MODE_VERIFYING   = 4'd5,
		MODE_CONFIRMING  = 4'd6,
		MODE_READY       = 4'd7,
		MODE_DEGRADED    = 4'd8
	} mode_t;

	typedef enum logic [2:0] {
		CMD_NONE     = 3'd0,
		CMD_WAKE     = 3'd1,
		CMD_IDENTIFY = 3'd2,
		CMD_CONFIG   = 3'd3,
		CMD_RAISE    = 3'd4,
		CMD_RESTART  = 3'd5,
		CMD_GSV_ON   = 3'd6,
		CMD_GSV_OFF  = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		REG_COMMAND_GAP     = 3'd0,
		REG_WAKE_DELAY      = 3'd1,
		REG_IDENTIFY_WINDOW = 3'd2,
		REG_VERIFY_WINDOW   = 3'd3,
		REG_RESTART_SETTLE  = 3'd4,
		REG_MIN_UPDATES     = 3'd5,
		REG_MAX_ATTEMPTS    = 3'd6,
		REG_RATE_SETTABLE   = 3'd7
	} cfg_reg_t;

	localparam logic [2:0] RATE_WALK [8] = '{
		3'((0 + 1) % int'(RATE_CANDIDATES)), 3'((1 + 1) % int'(RATE_CANDIDATES)),
		3'((2 + 1) % int'(RATE_CANDIDATES)), 3'((3 + 1) % int'(RATE_CANDIDATES)),
		3'((4 + 1) % int'(RATE_CANDIDATES)), 3'((5 + 1) % int'(RATE_CANDIDATES)),
		3'((6 + 1) % int'(RATE_CANDIDATES)), 3'((7 + 1) % int'(RATE_CANDIDATES))
	};

endpackage

// ===== rtl/core/gnss_receiver_config_sequencer.sv =====
// Pipeline: a tick is taken into the input register, and its result is loaded into the
// result register once that register is empty or not stalled, and is offered from there.
// Throughput: one tick per cycle while the result output is not stalled; the state update completes within that cycle.
// Reset: arst_n clears all sequencer state to idle and loads the default register
// values; no clearing pass is needed, the block accepts ticks right after reset.
// ----------------------------------------------------------------------------
// Receiver bring-up sequencer
// Steps the wake, identify, configure, verify and baud raise sequence of a
// serial satellite receiver, one command at most per service tick.
// ----------------------------------------------------------------------------
module gnss_receiver_config_sequencer (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,

	input  logic        item_valid,
	output logic        item_stall,
	input  logic        action,
	input  logic [31:0] now_ms,
	input  logic [31:0] update_count,
	input  logic [31:0] unrequested_count,
	input  logic        identified,
	input  logic [1:0]  restart_kind,
	input  logic        gsv_wanted,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  command,
	output logic [3:0]  command_arg,
	output logic        clear_validity,
	output logic [3:0]  mode,
	output logic [2:0]  rate_index,
	output logic [3:0]  attempt_count
);

	logic [15:0] command_gap_q;
	logic [15:0] wake_delay_q;
	logic [15:0] identify_window_q;
	logic [15:0] verify_window_q;
	logic [15:0] restart_settle_q;
	logic [7:0]  min_updates_q;
	logic [3:0]  max_attempts_q;
	logic        rate_settable_q;

	logic        valid_s1;
	logic        action_s1;
	logic [31:0] now_s1;
	logic [31:0] upd_s1;
	logic [31:0] unreq_s1;
	logic        ident_s1;
	logic [1:0]  kind_s1;
	logic        want_s1;

	logic        valid_s2;
	gnss_cfg_pkg::cmd_t  cmd_s2;
	logic [3:0]  arg_s2;
	logic        clear_s2;
	gnss_cfg_pkg::mode_t mode_s2;
	logic [2:0]  rate_s2;
	logic [3:0]  attempts_s2;

	gnss_cfg_pkg::mode_t mode_q, mode_d;
	logic [3:0]  next_sentence_q, next_sentence_d;
	logic [31:0] last_send_q, last_send_d;
	logic [31:0] verify_start_q, verify_start_d;
	logic [31:0] verify_upd_q, verify_upd_d;
	logic [31:0] verify_unreq_q, verify_unreq_d;
	logic [3:0]  attempts_q, attempts_d;
	logic [2:0]  rate_q, rate_d;
	logic [3:0]  rates_tried_q, rates_tried_d;
	logic [2:0]  rate_before_q, rate_before_d;
	logic        pend_valid_q, pend_valid_d;
	logic [1:0]  pend_kind_q, pend_kind_d;
	logic        gsv_q, gsv_d;

	gnss_cfg_pkg::cmd_t cmd_d;
	logic [3:0]  arg_d;
	logic        clear_d;

	logic        advance;
	logic [31:0] since_send;
	logic [31:0] since_verify;
	logic [31:0] upd_delta;
	logic        verify_fail;
	logic        walk_ok;
	logic        raise_ok;
	logic        default_ok;
	logic        before_ok;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && valid_s2 && result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_gap_q     <= 16'd100;
			wake_delay_q      <= 16'd500;
			identify_window_q <= 16'd1000;
			verify_window_q   <= 16'd3000;
			restart_settle_q  <= 16'd2000;
			min_updates_q     <= 8'd2;
			max_attempts_q    <= 4'd3;
			rate_settable_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gnss_cfg_pkg::REG_COMMAND_GAP:     command_gap_q     <= cfg_data;
				gnss_cfg_pkg::REG_WAKE_DELAY:      wake_delay_q      <= cfg_data;
				gnss_cfg_pkg::REG_IDENTIFY_WINDOW: identify_window_q <= cfg_data;
				gnss_cfg_pkg::REG_VERIFY_WINDOW:   verify_window_q   <= cfg_data;
				gnss_cfg_pkg::REG_RESTART_SETTLE:  restart_settle_q  <= cfg_data;
				gnss_cfg_pkg::REG_MIN_UPDATES:     min_updates_q     <= cfg_data[7:0];
				gnss_cfg_pkg::REG_MAX_ATTEMPTS:    max_attempts_q    <= cfg_data[3:0];
				gnss_cfg_pkg::REG_RATE_SETTABLE:   rate_settable_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			action_s1 <= action;
			now_s1    <= now_ms;
			upd_s1    <= update_count;
			unreq_s1  <= unrequested_count;
			ident_s1  <= identified;
			kind_s1   <= restart_kind;
			want_s1   <= gsv_wanted;
		end
	end

	assign since_send   = now_s1 - last_send_q;
	assign since_verify = now_s1 - verify_start_q;
	assign upd_delta    = upd_s1 - verify_upd_q;
	assign verify_fail  = (upd_delta < {24'd0, min_updates_q}) || (unreq_s1 != verify_unreq_q);
	assign walk_ok      = (rates_tried_q < gnss_cfg_pkg::RATE_CANDIDATES) && rate_settable_q;
	assign raise_ok     = (rate_q != gnss_cfg_pkg::TARGET_RATE_INDEX) && rate_settable_q
		&& ({1'b0, gnss_cfg_pkg::TARGET_RATE_INDEX} < gnss_cfg_pkg::RATE_CANDIDATES);
	assign default_ok   = rate_settable_q
		&& ({1'b0, gnss_cfg_pkg::DEFAULT_RATE_INDEX} < gnss_cfg_pkg::RATE_CANDIDATES);
	assign before_ok    = rate_settable_q
		&& ({1'b0, rate_before_q} < gnss_cfg_pkg::RATE_CANDIDATES);

	always_comb begin
		logic [3:0] ns_base;
		logic       do_send;
		logic [3:0] ns_next;
		cmd_d           = gnss_cfg_pkg::CMD_NONE;
		arg_d           = 4'd0;
		clear_d         = 1'b0;
		mode_d          = mode_q;
		next_sentence_d = next_sentence_q;
		last_send_d     = last_send_q;
		verify_start_d  = verify_start_q;
		verify_upd_d    = verify_upd_q;
		verify_unreq_d  = verify_unreq_q;
		attempts_d      = attempts_q;
		rate_d          = rate_q;
		rates_tried_d   = rates_tried_q;
		rate_before_d   = rate_before_q;
		pend_valid_d    = pend_valid_q;
		pend_kind_d     = pend_kind_q;
		gsv_d           = gsv_q;
		ns_base         = next_sentence_q;
		do_send         = 1'b0;
		ns_next         = 4'd0;
		if (action_s1) begin
			pend_valid_d = 1'b1;
			pend_kind_d  = kind_s1;
		end else if (pend_valid_q) begin
			cmd_d        = gnss_cfg_pkg::CMD_RESTART;
			arg_d        = {2'b00, pend_kind_q};
			last_send_d  = now_s1;
			pend_valid_d = 1'b0;
			if (pend_kind_q == gnss_cfg_pkg::FACTORY_KIND) begin
				clear_d = 1'b1;
				if (default_ok) begin
					rate_d = gnss_cfg_pkg::DEFAULT_RATE_INDEX;
				end
				mode_d = gnss_cfg_pkg::MODE_RESTARTING;
			end
		end else begin
			case (mode_q)
				gnss_cfg_pkg::MODE_IDLE: begin
					attempts_d  = 4'd1;
					cmd_d       = gnss_cfg_pkg::CMD_WAKE;
					last_send_d = now_s1;
					mode_d      = gnss_cfg_pkg::MODE_WAKING;
				end
				gnss_cfg_pkg::MODE_RESTARTING: begin
					if (since_send >= {16'd0, restart_settle_q}) begin
						attempts_d  = 4'd1;
						cmd_d       = gnss_cfg_pkg::CMD_WAKE;
						last_send_d = now_s1;
						mode_d      = gnss_cfg_pkg::MODE_WAKING;
					end
				end
				gnss_cfg_pkg::MODE_WAKING: begin
					if (since_send >= {16'd0, wake_delay_q}) begin
						cmd_d       = gnss_cfg_pkg::CMD_IDENTIFY;
						last_send_d = now_s1;
						mode_d      = gnss_cfg_pkg::MODE_IDENTIFYING;
					end
				end
				gnss_cfg_pkg::MODE_IDENTIFYING: begin
					if (ident_s1 || since_send >= {16'd0, identify_window_q}) begin
						gsv_d   = 1'b0;
						mode_d  = gnss_cfg_pkg::MODE_SENDING;
						ns_base = 4'd0;
						do_send = 1'b1;
					end
				end
				gnss_cfg_pkg::MODE_SENDING: begin
					if (since_send >= {16'd0, command_gap_q}) begin
						do_send = 1'b1;
					end
				end
				gnss_cfg_pkg::MODE_VERIFYING: begin
					if (since_verify >= {16'd0, verify_window_q}) begin
						if (verify_fail) begin
							if (upd_s1 == verify_upd_q && walk_ok) begin
								rate_d        = gnss_cfg_pkg::RATE_WALK[rate_q];
								rates_tried_d = rates_tried_q + 4'd1;
								attempts_d    = 4'd1;
								cmd_d         = gnss_cfg_pkg::CMD_WAKE;
								last_send_d   = now_s1;
								mode_d        = gnss_cfg_pkg::MODE_WAKING;
							end else if (attempts_q >= max_attempts_q) begin
								mode_d = gnss_cfg_pkg::MODE_DEGRADED;
							end else begin
								attempts_d  = attempts_q + 4'd1;
								cmd_d       = gnss_cfg_pkg::CMD_WAKE;
								last_send_d = now_s1;
								mode_d      = gnss_cfg_pkg::MODE_WAKING;
							end
						end else begin
							verify_start_d = now_s1;
							verify_upd_d   = upd_s1;
							verify_unreq_d = unreq_s1;
							if (raise_ok) begin
								rate_before_d = rate_q;
								cmd_d         = gnss_cfg_pkg::CMD_RAISE;
								last_send_d   = now_s1;
								rate_d        = gnss_cfg_pkg::TARGET_RATE_INDEX;
								mode_d        = gnss_cfg_pkg::MODE_CONFIRMING;
							end else begin
								mode_d = gnss_cfg_pkg::MODE_READY;
							end
						end
					end
				end
				gnss_cfg_pkg::MODE_CONFIRMING: begin
					if (upd_s1 != verify_upd_q) begin
						mode_d = gnss_cfg_pkg::MODE_READY;
					end else if (since_verify >= {16'd0, verify_window_q}) begin
						if (before_ok) begin
							rate_d = rate_before_q;
						end
						mode_d = gnss_cfg_pkg::MODE_READY;
					end
				end
				default: begin
				end
			endcase
			if (do_send) begin
				ns_next         = ns_base + 4'd1;
				cmd_d           = gnss_cfg_pkg::CMD_CONFIG;
				arg_d           = ns_base;
				last_send_d     = now_s1;
				next_sentence_d = ns_next;
				if (ns_next >= gnss_cfg_pkg::SENTENCE_COUNT) begin
					mode_d         = gnss_cfg_pkg::MODE_VERIFYING;
					verify_start_d = now_s1;
					verify_upd_d   = upd_s1;
					verify_unreq_d = unreq_s1;
				end
			end
			if (mode_d == gnss_cfg_pkg::MODE_READY && gsv_q != want_s1) begin
				cmd_d       = want_s1 ? gnss_cfg_pkg::CMD_GSV_ON : gnss_cfg_pkg::CMD_GSV_OFF;
				arg_d       = 4'd0;
				last_send_d = now_s1;
				gsv_d       = want_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= gnss_cfg_pkg::MODE_IDLE;
			next_sentence_q <= 4'd0;
			last_send_q     <= 32'd0;
			verify_start_q  <= 32'd0;
			verify_upd_q    <= 32'd0;
			verify_unreq_q  <= 32'd0;
			attempts_q      <= 4'd0;
			rate_q          <= gnss_cfg_pkg::DEFAULT_RATE_INDEX;
			rates_tried_q   <= 4'd0;
			rate_before_q   <= 3'd0;
			pend_valid_q    <= 1'b0;
			pend_kind_q     <= 2'd0;
			gsv_q           <= 1'b0;
		end else if (advance) begin
			mode_q          <= mode_d;
			next_sentence_q <= next_sentence_d;
			last_send_q     <= last_send_d;
			verify_start_q  <= verify_start_d;
			verify_upd_q    <= verify_upd_d;
			verify_unreq_q  <= verify_unreq_d;
			attempts_q      <= attempts_d;
			rate_q          <= rate_d;
			rates_tried_q   <= rates_tried_d;
			rate_before_q   <= rate_before_d;
			pend_valid_q    <= pend_valid_d;
			pend_kind_q     <= pend_kind_d;
			gsv_q           <= gsv_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s2      <= cmd_d;
			arg_s2      <= arg_d;
			clear_s2    <= clear_d;
			mode_s2     <= mode_d;
			rate_s2     <= rate_d;
			attempts_s2 <= attempts_d;
		end
	end

	assign result_valid   = valid_s2;
	assign command        = cmd_s2;
	assign command_arg    = arg_s2;
	assign clear_validity = clear_s2;
	assign mode           = mode_s2;
	assign rate_index     = rate_s2;
	assign attempt_count  = attempts_s2;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && clear_s2 |-> cmd_s2 == gnss_cfg_pkg::CMD_RESTART
			&& arg_s2 == {2'b00, gnss_cfg_pkg::FACTORY_KIND})
		else $error("validity clear without a factory restart command");

	assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, rate_q} < gnss_cfg_pkg::RATE_CANDIDATES)
			|| (rate_q == gnss_cfg_pkg::DEFAULT_RATE_INDEX))
		else $error("baud index is neither a candidate nor the default");

	assert property (@(posedge clk) disable iff (!arst_n)
		rates_tried_q <= gnss_cfg_pkg::RATE_CANDIDATES)
		else $error("baud walk went past the candidate count");

	assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == gnss_cfg_pkg::MODE_SENDING |-> next_sentence_q < gnss_cfg_pkg::SENTENCE_COUNT)
		else $error("sending mode with no sentence left");

	assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 |=> pend_valid_q && (pend_kind_q == $past(kind_s1)))
		else $error("restart request transfer was not recorded");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Receiver bring-up sequencer testbench
// Drives service ticks and restart requests through the item channel, writes
// the timing and retry registers between phases, and checks every command,
// argument, validity clear, mode, rate and attempt result against a cycle-free model of the sequencer.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct packed {
		logic        act;
		logic [31:0] now;
		logic [31:0] upd;
		logic [31:0] unreq;
		logic        ident;
		logic [1:0]  kind;
		logic        want;
	} tick_t;

	typedef struct packed {
		gnss_cfg_pkg::cmd_t  cmd;
		logic [3:0]          arg;
		logic                clr;
		gnss_cfg_pkg::mode_t md;
		logic [2:0]          rate;
		logic [3:0]          att;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [15:0] cfg_data = 16'd0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        action = 1'b0;
	logic [31:0] now_ms = 32'd0;
	logic [31:0] update_count = 32'd0;
	logic [31:0] unrequested_count = 32'd0;
	logic        identified = 1'b0;
	logic [1:0]  restart_kind = 2'd0;
	logic        gsv_wanted = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  command;
	logic [3:0]  command_arg;
	logic        clear_validity;
	logic [3:0]  mode;
	logic [2:0]  rate_index;
	logic [3:0]  attempt_count;

	gnss_receiver_config_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.action(action),
		.now_ms(now_ms),
		.update_count(update_count),
		.unrequested_count(unrequested_count),
		.identified(identified),
		.restart_kind(restart_kind),
		.gsv_wanted(gsv_wanted),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.command(command),
		.command_arg(command_arg),
		.clear_validity(clear_validity),
		.mode(mode),
		.rate_index(rate_index),
		.attempt_count(attempt_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tick_t    tick_queue [$];
	outcome_t expected_commands [$];
	int       ticks_queued = 0;
	int       ticks_taken = 0;
	int       results_seen = 0;
	int       err_count = 0;
	int       send_idle_pct = 0;
	int       stall_pct = 0;
	int       hold_requests = 0;
	int       holds_served = 0;
	int       hold_left = 0;
	bit       item_taken = 1'b0;

	// Sequencer state as the model keeps it.
	gnss_cfg_pkg::mode_t st_mode = gnss_cfg_pkg::MODE_IDLE;
	logic [3:0]  sent_idx = 4'd0;
	logic [31:0] last_cmd_ms = 32'd0;
	logic [31:0] window_start_ms = 32'd0;
	logic [31:0] upd_mark = 32'd0;
	logic [31:0] unreq_mark = 32'd0;
	logic [3:0]  attempt_num = 4'd0;
	logic [2:0]  cur_rate = gnss_cfg_pkg::DEFAULT_RATE_INDEX;
	logic [3:0]  walk_steps = 4'd0;
	logic [2:0]  saved_rate = 3'd0;
	logic        restart_pending = 1'b0;
	logic [1:0]  restart_pending_kind = 2'd0;
	logic        gsv_on = 1'b0;
	logic [15:0] gap_ms = 16'd100;
	logic [15:0] wake_ms = 16'd500;
	logic [15:0] ident_ms = 16'd1000;
	logic [15:0] verify_ms = 16'd3000;
	logic [15:0] settle_ms = 16'd2000;
	logic [7:0]  min_updates = 8'd2;
	logic [3:0]  max_tries = 4'd3;
	logic        rate_ok = 1'b1;
	outcome_t    outcome;

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s: got %0d expected %0d",
				results_seen, name, got, want));
	endtask

	task automatic issue(input gnss_cfg_pkg::cmd_t c, input logic [3:0] a,
			input logic [31:0] at_ms);
		outcome.cmd = c;
		outcome.arg = a;
		last_cmd_ms = at_ms;
	endtask

	task automatic start_wake(input logic [31:0] at_ms);
		issue(gnss_cfg_pkg::CMD_WAKE, 4'd0, at_ms);
		st_mode = gnss_cfg_pkg::MODE_WAKING;
	endtask

	task automatic mark_window(input tick_t tk);
		window_start_ms = tk.now;
		upd_mark = tk.upd;
		unreq_mark = tk.unreq;
	endtask

	task automatic send_sentence(input tick_t tk);
		issue(gnss_cfg_pkg::CMD_CONFIG, sent_idx, tk.now);
		sent_idx = sent_idx + 4'd1;
		if (sent_idx >= gnss_cfg_pkg::SENTENCE_COUNT) begin
			st_mode = gnss_cfg_pkg::MODE_VERIFYING;
			mark_window(tk);
		end
	endtask

	function automatic bit adopt_rate(input logic [3:0] idx);
		if (idx >= gnss_cfg_pkg::RATE_CANDIDATES || !rate_ok)
			return 1'b0;
		cur_rate = idx[2:0];
		return 1'b1;
	endfunction

	function automatic bit step_rate();
		int nxt;
		if (walk_steps >= gnss_cfg_pkg::RATE_CANDIDATES || !rate_ok)
			return 1'b0;
		nxt = (int'(cur_rate) + 1) % int'(gnss_cfg_pkg::RATE_CANDIDATES);
		cur_rate = nxt[2:0];
		walk_steps = walk_steps + 4'd1;
		return 1'b1;
	endfunction

	task automatic sequence_step(input tick_t tk, output outcome_t res);
		logic [31:0] since_cmd;
		logic [31:0] since_window;
		bit raised;
		outcome = '{gnss_cfg_pkg::CMD_NONE, 4'd0, 1'b0, gnss_cfg_pkg::MODE_IDLE, 3'd0, 4'd0};
		since_cmd = tk.now - last_cmd_ms;
		since_window = tk.now - window_start_ms;
		if (tk.act) begin
			restart_pending = 1'b1;
			restart_pending_kind = tk.kind;
		end else if (restart_pending) begin
			issue(gnss_cfg_pkg::CMD_RESTART, {2'b00, restart_pending_kind}, tk.now);
			restart_pending = 1'b0;
			if (restart_pending_kind == gnss_cfg_pkg::FACTORY_KIND) begin
				outcome.clr = 1'b1;
				void'(adopt_rate({1'b0, gnss_cfg_pkg::DEFAULT_RATE_INDEX}));
				st_mode = gnss_cfg_pkg::MODE_RESTARTING;
			end
		end else begin
			case (st_mode)
				gnss_cfg_pkg::MODE_IDLE: begin
					attempt_num = 4'd1;
					start_wake(tk.now);
				end
				gnss_cfg_pkg::MODE_RESTARTING: begin
					if (since_cmd >= settle_ms) begin
						attempt_num = 4'd1;
						start_wake(tk.now);
					end
				end
				gnss_cfg_pkg::MODE_WAKING: begin
					if (since_cmd >= wake_ms) begin
						issue(gnss_cfg_pkg::CMD_IDENTIFY, 4'd0, tk.now);
						st_mode = gnss_cfg_pkg::MODE_IDENTIFYING;
					end
				end
				gnss_cfg_pkg::MODE_IDENTIFYING: begin
					if (tk.ident || since_cmd >= ident_ms) begin
						sent_idx = 4'd0;
						gsv_on = 1'b0;
						st_mode = gnss_cfg_pkg::MODE_SENDING;
						send_sentence(tk);
					end
				end
				gnss_cfg_pkg::MODE_SENDING: begin
					if (since_cmd >= gap_ms)
						send_sentence(tk);
				end
				gnss_cfg_pkg::MODE_VERIFYING: begin
					if (since_window >= verify_ms) begin
						if (tk.upd - upd_mark < min_updates || tk.unreq != unreq_mark) begin
							// A silent receiver steps to the next baud candidate while the walk allows it, and retries otherwise.
							if (tk.upd == upd_mark && step_rate()) begin
								attempt_num = 4'd1;
								start_wake(tk.now);
							end else if (attempt_num >= max_tries) begin
								st_mode = gnss_cfg_pkg::MODE_DEGRADED;
							end else begin
								attempt_num = attempt_num + 4'd1;
								start_wake(tk.now);
							end
						end else begin
							raised = 1'b0;
							if (cur_rate != gnss_cfg_pkg::TARGET_RATE_INDEX && rate_ok &&
									gnss_cfg_pkg::TARGET_RATE_INDEX <
									gnss_cfg_pkg::RATE_CANDIDATES) begin
								saved_rate = cur_rate;
								issue(gnss_cfg_pkg::CMD_RAISE, 4'd0, tk.now);
								raised = adopt_rate({1'b0, gnss_cfg_pkg::TARGET_RATE_INDEX});
							end
							st_mode = raised ? gnss_cfg_pkg::MODE_CONFIRMING
								: gnss_cfg_pkg::MODE_READY;
							mark_window(tk);
						end
					end
				end
				gnss_cfg_pkg::MODE_CONFIRMING: begin
					if (tk.upd != upd_mark) begin
						st_mode = gnss_cfg_pkg::MODE_READY;
					end else if (since_window >= verify_ms) begin
						void'(adopt_rate({1'b0, saved_rate}));
						st_mode = gnss_cfg_pkg::MODE_READY;
					end
				end
				default: begin
				end
			endcase
			if (st_mode == gnss_cfg_pkg::MODE_READY && gsv_on != tk.want) begin
				issue(tk.want ? gnss_cfg_pkg::CMD_GSV_ON : gnss_cfg_pkg::CMD_GSV_OFF, 4'd0,
					tk.now);
				gsv_on = tk.want;
			end
		end
		outcome.md = st_mode;
		outcome.rate = cur_rate;
		outcome.att = attempt_num;
		res = outcome;
	endtask

	always @(posedge clk) begin : monitor
		outcome_t predicted;
		outcome_t oldest;
		item_taken = arst_n && item_valid && !item_stall;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (gnss_cfg_pkg::cfg_reg_t'(cfg_index))
					gnss_cfg_pkg::REG_COMMAND_GAP:     gap_ms = cfg_data;
					gnss_cfg_pkg::REG_WAKE_DELAY:      wake_ms = cfg_data;
					gnss_cfg_pkg::REG_IDENTIFY_WINDOW: ident_ms = cfg_data;
					gnss_cfg_pkg::REG_VERIFY_WINDOW:   verify_ms = cfg_data;
					gnss_cfg_pkg::REG_RESTART_SETTLE:  settle_ms = cfg_data;
					gnss_cfg_pkg::REG_MIN_UPDATES:     min_updates = cfg_data[7:0];
					gnss_cfg_pkg::REG_MAX_ATTEMPTS:    max_tries = cfg_data[3:0];
					gnss_cfg_pkg::REG_RATE_SETTABLE:   rate_ok = cfg_data[0];
					default: begin
					end
				endcase
			end
			if (item_taken) begin
				sequence_step('{action, now_ms, update_count, unrequested_count, identified,
					restart_kind, gsv_wanted}, predicted);
				expected_commands.push_back(predicted);
				ticks_taken++;
			end
			if (result_valid && !result_stall) begin
				if (expected_commands.size() == 0) begin
					report_error("result transfer with no result expected");
				end else begin
					oldest = expected_commands.pop_front();
					check_field("command", command, oldest.cmd);
					check_field("command_arg", command_arg, oldest.arg);
					check_field("clear_validity", clear_validity, oldest.clr);
					check_field("mode", mode, oldest.md);
					check_field("rate_index", rate_index, oldest.rate);
					check_field("attempt_count", attempt_count, oldest.att);
				end
				results_seen++;
			end
		end
	end

	always @(negedge clk) begin : feed
		tick_t nxt;
		if (arst_n && (!item_valid || item_taken)) begin
			if (tick_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = tick_queue.pop_front();
				item_valid <= 1'b1;
				action <= nxt.act;
				now_ms <= nxt.now;
				update_count <= nxt.upd;
				unrequested_count <= nxt.unreq;
				identified <= nxt.ident;
				restart_kind <= nxt.kind;
				gsv_wanted <= nxt.want;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served = holds_served + 1;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic add_tick(input logic a, input logic [31:0] n, input logic [31:0] u,
			input logic [31:0] q, input logic i, input logic [1:0] k, input logic w);
		tick_queue.push_back(tick_t'{a, n, u, q, i, k, w});
		ticks_queued++;
	endtask

	task automatic write_reg(input gnss_cfg_pkg::cfg_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (ticks_taken != ticks_queued || expected_commands.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [31:0] t;
		logic [31:0] u;
		logic [31:0] r;
		logic [15:0] vals [8];
		logic        want;
		int          step_max;
		int          upd_max;
		int          beh;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: restart overwrite, factory restart and settle, a silent
		// verify that walks the rate, then a clean pass with raise and confirm, GSV on and off, and a plain restart.
		t = 32'hFFFF_FFFF;
		u = 32'hFFFF_FFFF;
		r = 32'hFFFF_FFFF;
		add_tick(1'b1, 32'h0, 32'h0, 32'h0, 1'b0, 2'd1, 1'b0);
		add_tick(1'b1, t, u, r, 1'b1, gnss_cfg_pkg::FACTORY_KIND, 1'b1);
		add_tick(1'b0, t, u, r, 1'b1, 2'd0, 1'b1);
		t += 1999;
		add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b1);
		t += 1;
		add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b1);
		t += 500;
		add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b1);
		t += 999;
		add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b1);
		t += 1;
		add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b1);
		repeat (3) begin
			t += 100;
			add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b1);
		end
		t += 3000;
		add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b1);
		t += 500;
		add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b1);
		add_tick(1'b0, t, u, r, 1'b1, 2'd0, 1'b1);
		repeat (3) begin
			t += 100;
			add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b1);
		end
		t += 3000;
		u += 2;
		add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b1);
		t += 1;
		add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b1);
		u += 1;
		add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b1);
		add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b0);
		add_tick(1'b1, t, u, r, 1'b0, 2'd2, 1'b0);
		add_tick(1'b0, t, u, r, 1'b0, 2'd0, 1'b0);
		wait_drained();

		for (int p = 0; p < 8; p++) begin
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 63; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 63; end
				default: begin send_idle_pct = 33; stall_pct = 33; end
			endcase
			case (p)
				0, 6: begin
					vals[0] = 16'($urandom_range(0, 20));
					vals[1] = 16'($urandom_range(0, 40));
					vals[2] = 16'($urandom_range(0, 60));
					vals[3] = 16'($urandom_range(0, 80));
					vals[4] = 16'($urandom_range(0, 60));
					vals[5] = 16'($urandom_range(0, 4));
					vals[6] = 16'($urandom_range(0, 4));
					vals[7] = (p == 0) ? 16'd1 : 16'($urandom_range(0, 1));
					step_max = 30;
					upd_max = 3;
				end
				1: begin
					vals = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'hFFFE};
					step_max = 3;
					upd_max = 2;
				end
				2: begin
					vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF,
						16'h0001, 16'h0001};
					step_max = 40000;
					upd_max = 150;
				end
				4: begin
					for (int i = 0; i < 5; i++)
						vals[i] = 16'($urandom_range(0, 50));
					vals[5] = 16'($urandom_range(0, 3));
					vals[6] = 16'h0;
					vals[7] = 16'h0;
					step_max = 40;
					upd_max = 3;
				end
				5: begin
					for (int i = 0; i < 8; i++)
						vals[i] = 16'($urandom_range(0, 65535));
					step_max = 140000;
					upd_max = 400;
				end
				default: begin
					for (int i = 0; i < 5; i++)
						vals[i] = 16'($urandom_range(0, 200));
					vals[5] = (p == 3) ? 16'($urandom_range(0, 6)) : 16'h0;
					vals[6] = 16'($urandom_range(1, 5));
					vals[7] = 16'h1;
					step_max = 120;
					upd_max = 4;
				end
			endcase
			for (int i = 0; i < 8; i++)
				write_reg(gnss_cfg_pkg::cfg_reg_t'(i), vals[i]);

			t = $urandom();
			u = $urandom();
			r = $urandom();
			want = 1'($urandom_range(0, 1));
			beh = 0;
			for (int n = 0; n < 200; n++) begin
				// Segments of healthy, silent or noisy receiver behavior.
				if (n % 16 == 0)
					beh = $urandom_range(0, 9);
				if ($urandom_range(0, 99) < 6) begin
					add_tick(1'b1, $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)),
						2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
				end else if ($urandom_range(0, 99) < 2) begin
					add_tick(1'b0, $urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)),
						2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
				end else begin
					t += $urandom_range(0, step_max);
					if (beh < 6)
						u += $urandom_range(0, upd_max);
					else if (beh >= 8)
						r += $urandom_range(0, 1);
					if ($urandom_range(0, 99) < 8)
						want = !want;
					add_tick(1'b0, t, u, r, $urandom_range(0, 99) < 25,
						2'($urandom_range(0, 3)), want);
				end
			end
			if (p == 0) begin
				@(posedge clk);
				hold_requests++;
			end
			wait_drained();
		end

		if (err_count == 0 && expected_commands.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
